// ===== rtl/dsf3_pkg.sv =====
// Shared constants for the 3x3 diagonal smoothing filter.
package dsf3_pkg;

  localparam int MAX_LINE = 1024;
  localparam int LINE_AW  = $clog2(MAX_LINE);
  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 3 * CHAN_W;
  localparam int LEN_W    = 11;
  localparam int CNT_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT  = 1'b1;

  localparam logic [LEN_W-1:0] LINE_LENGTH_RST = LEN_W'(1024);
  localparam logic [CNT_W-1:0] LINE_COUNT_RST  = CNT_W'(768);

  localparam logic [LEN_W-1:0] LEN_MIN_M1 = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX_M1 = LEN_W'(MAX_LINE - 1);
  localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(MAX_LINE);
  localparam logic [CNT_W-1:0] CNT_MIN_M1 = CNT_W'(2);

endpackage

// ===== rtl/dsf3_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module dsf3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/diagonal_smoothing_filter_3x3_core.sv =====
// Top level of the 3x3 diagonal smoothing filter.
//
// Pixels enter on the s_axis channel in raster order, one request per pixel,
// red in the low byte of tdata. Each interior pixel of the frame produces one
// request on m_axis holding the smoothed channels, with tlast on the last
// interior pixel of a line and tuser on the last interior pixel of the frame.
// Border pixels produce nothing. The cfg port sets line length and line count
// and must be written only while the block is idle; nothing enforces this.
// A pixel's window is complete when its lower right neighbour arrives; that
// pixel is held in the read stage and the result in the output register.
// The block takes one pixel per cycle for as long as the output is taken:
// each line store is read once and written once per cycle, its read
// data returning in the cycle after the address.
// When m_axis stalls, the finished result stays in the output register and
// s_axis_tready is low while the read stage holds a pixel that has a result.
// Reset clears the counters, window and output valid and restores the
// default geometry of 1024 by 768; the line stores need no clearing, since
// what they return on the first two lines of a frame is never used.
module diagonal_smoothing_filter_3x3_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dsf3_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dsf3_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // red_in[7:0], green_in[15:8], blue_in[23:16]
  input  logic [dsf3_pkg::PIX_W-1:0]    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic [dsf3_pkg::PIX_W-1:0]    m_axis_tdata,
  // line_end
  output logic                          m_axis_tlast,
  // frame_end
  output logic                          m_axis_tuser
);

  import dsf3_pkg::*;

  function automatic logic [CHAN_W-1:0] smooth_chan(
    input logic [CHAN_W-1:0] c,
    input logic [CHAN_W-1:0] d0,
    input logic [CHAN_W-1:0] d1,
    input logic [CHAN_W-1:0] d2,
    input logic [CHAN_W-1:0] d3
  );
    logic [CHAN_W+3:0] acc;
    acc = {1'b0, c, 3'b000} + {2'b00, c, 2'b00}
        + (CHAN_W+4)'(d0) + (CHAN_W+4)'(d1) + (CHAN_W+4)'(d2) + (CHAN_W+4)'(d3);
    return acc[CHAN_W+3:4];
  endfunction

  logic [LEN_W-1:0]   line_length_q;
  logic [CNT_W-1:0]   line_count_q;
  logic [LEN_W-1:0]   len_m1;
  logic [CNT_W-1:0]   cnt_m1;
  logic [LINE_AW-1:0] col_q, col_d;
  logic [CNT_W-1:0]   row_q, row_d;
  logic               lend, fend, emit, accept;

  logic               s1_valid_q;
  logic [PIX_W-1:0]   s1_px_q;
  logic [LINE_AW-1:0] s1_col_q;
  logic               s1_emit_q, s1_lend_q, s1_fend_q;
  logic               out_free, s1_adv;

  logic [PIX_W-1:0]   up2, up1;
  logic [PIX_W-1:0]   w01_q, w21_q, w02_q, w12_q, w22_q;
  logic [PIX_W-1:0]   smooth_px;

  logic               m_valid_q;
  logic [PIX_W-1:0]   m_data_q;
  logic               m_last_q, m_user_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= LINE_LENGTH_RST;
      line_count_q  <= LINE_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LINE_LENGTH: line_length_q <= cfg_wdata_i[LEN_W-1:0];
        CFG_LINE_COUNT:  line_count_q  <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Line length and count below 3 are raised to 3; length is capped at 1024.
  always_comb begin
    if (line_length_q < LEN_W'(3)) begin
      len_m1 = LEN_MIN_M1;
    end else if (line_length_q > LEN_MAX) begin
      len_m1 = LEN_MAX_M1;
    end else begin
      len_m1 = line_length_q - LEN_W'(1);
    end
    if (line_count_q < CNT_W'(3)) begin
      cnt_m1 = CNT_MIN_M1;
    end else begin
      cnt_m1 = line_count_q - CNT_W'(1);
    end
  end

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && (!s1_emit_q || out_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign lend = LEN_W'(col_q) >= len_m1;
  assign fend = lend && (row_q >= cnt_m1);
  assign emit = (col_q >= LINE_AW'(2)) && (row_q >= CNT_W'(2));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (lend) begin
      col_d = '0;
      row_d = fend ? '0 : row_q + CNT_W'(1);
    end else begin
      col_d = col_q + LINE_AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Read stage: line store data for the accepted pixel arrives here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= s_axis_tdata;
      s1_col_q  <= col_q;
      s1_emit_q <= emit;
      s1_lend_q <= lend;
      s1_fend_q <= fend;
    end
  end

  // Consecutive pixels never share a column, so the write-back of one pixel
  // and the read of the next always touch different entries.
  dsf3_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_LINE)
  ) u_older_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (up1),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (up2)
  );

  dsf3_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_LINE)
  ) u_newer_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (s1_px_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (up1)
  );

  // Window columns that are still read after the shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w01_q <= '0;
      w21_q <= '0;
      w02_q <= '0;
      w12_q <= '0;
      w22_q <= '0;
    end else if (s1_adv) begin
      w01_q <= w02_q;
      w21_q <= w22_q;
      w02_q <= up2;
      w12_q <= up1;
      w22_q <= s1_px_q;
    end
  end

  // The filter is evaluated on the window as it stands after the shift.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      smooth_px[ch*CHAN_W +: CHAN_W] = smooth_chan(
        w12_q[ch*CHAN_W +: CHAN_W],
        w01_q[ch*CHAN_W +: CHAN_W],
        w21_q[ch*CHAN_W +: CHAN_W],
        up2[ch*CHAN_W +: CHAN_W],
        s1_px_q[ch*CHAN_W +: CHAN_W]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_adv && s1_emit_q) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      m_data_q <= smooth_px;
      m_last_q <= s1_lend_q;
      m_user_q <= s1_fend_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ===== rtl/dsf3_checker.sv =====
// Port-level checks for the smoothing filter, bound to the top level.
module dsf3_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [dsf3_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [dsf3_pkg::CFG_W-1:0]    cfg_wdata_i,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [dsf3_pkg::PIX_W-1:0]    s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [dsf3_pkg::PIX_W-1:0]    m_axis_tdata,
  input logic                          m_axis_tlast,
  input logic                          m_axis_tuser
);

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // The last pixel of a frame is also the last of its line.
  a_frame_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end without line end");

  // With the output register empty, the input side is never held off.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A result cannot appear in the cycle right after reset.
  a_no_result_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result right after reset");

endmodule

bind diagonal_smoothing_filter_3x3_core dsf3_checker u_dsf3_checker (.*);
